// ----- src/gpio_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_pkg
// Command codes, default sizes and word layouts of the GPIO port controller.
// ----------------------------------------------------------------------------
package gpio_pkg;

   localparam int DEFAULT_PORTS = 4;
   localparam int DEFAULT_PINS  = 12;

   localparam int CMD_W      = 4;
   localparam int PORT_W     = 2;
   localparam int PIN_W      = 4;
   localparam int LEVELS_W   = 12;
   localparam int DRIVE_W    = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_DIR        = 4'd0,
      CMD_DATA       = 4'd1,
      CMD_TOGGLE     = 4'd2,
      CMD_READ       = 4'd3,
      CMD_IRQ_MODE   = 4'd4,
      CMD_ENABLE     = 4'd5,
      CMD_DISABLE    = 4'd6,
      CMD_IRQ_STATUS = 4'd7,
      CMD_CLEAR_EDGE = 4'd8,
      CMD_SAMPLE     = 4'd9
   } cmd_type;

endpackage : gpio_pkg
`default_nettype wire

// ----- src/gpio_port_with_pin_interrupts.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_port_with_pin_interrupts
// PORTS GPIO ports of PINS pins with direction, output latch, sampled levels
// and per-pin edge or level interrupts.
// ----------------------------------------------------------------------------
// Each request word carries one command for one port and pin, or a sample
// tick with the port's pin levels. One response word comes back per request,
// after the word passes the input register and then the read-modify-write of
// the port registers that loads the response register. Sustained throughput
// is one word per clock while rsp_tready does not stall the response; it is
// set by that single register update, which the next word sees at once. The
// response reports the addressed port's latch and direction after the command,
// the read bit, and irq, the OR of all unmasked pending pins of all ports.
module gpio_port_with_pin_interrupts
   import gpio_pkg::*;
#(
   parameter int PORTS = DEFAULT_PORTS,
   parameter int PINS  = DEFAULT_PINS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // port[1:0], pin[5:2], value[6], level_sense[7], both_edges[8],
   // rise_or_high[9], pin_levels[21:10], zero fill[23:22]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command[3:0]
   input  wire logic [CMD_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // read_bit[0], drive_data[12:1], drive_enable[24:13], irq[25],
   // zero fill[31:26]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   // input register
   logic                  in_valid_ff, in_valid_in;
   cmd_type               in_cmd_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rd_ff;
   logic [DRIVE_W-1:0]    dd_ff;
   logic [DRIVE_W-1:0]    de_ff;
   logic                  irq_ff;

   // port registers
   logic [PORTS-1:0][PINS-1:0] dir_ff,   dir_in;
   logic [PORTS-1:0][PINS-1:0] latch_ff, latch_in;
   logic [PORTS-1:0][PINS-1:0] sample_ff, sample_in;
   logic [PORTS-1:0][PINS-1:0] level_ff, level_in;
   logic [PORTS-1:0][PINS-1:0] dual_ff,  dual_in;
   logic [PORTS-1:0][PINS-1:0] pol_ff,   pol_in;
   logic [PORTS-1:0][PINS-1:0] mask_ff,  mask_in;
   logic [PORTS-1:0][PINS-1:0] edge_ff,  edge_in;

   logic                  move;
   logic [PORT_W-1:0]     f_port;
   logic [PIN_W-1:0]      f_pin;
   logic                  f_value;
   logic                  f_lsense;
   logic                  f_both;
   logic                  f_rise;
   logic [LEVELS_W-1:0]   f_levels;
   logic [PINS-1:0]       levels;
   logic [PINS-1:0]       bit_sel;
   logic                  port_ok;
   logic                  rd_in;
   logic [DRIVE_W-1:0]    dd_in;
   logic [DRIVE_W-1:0]    de_in;
   logic                  irq_in;
   logic                  irq_now;

   function automatic logic [PINS-1:0] pending(
      input logic [PINS-1:0] smp,
      input logic [PINS-1:0] pol,
      input logic [PINS-1:0] lvl,
      input logic [PINS-1:0] edg,
      input logic [PINS-1:0] msk
   );
      pending = (((~(smp ^ pol)) & lvl) | (edg & ~lvl)) & msk;
   endfunction

   function automatic logic [PINS-1:0] put_bit(
      input logic [PINS-1:0] x,
      input logic [PINS-1:0] b,
      input logic            on
   );
      put_bit = on ? (x | b) : (x & ~b);
   endfunction

   // handshake
   assign move         = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || move;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // field unpacking
   assign f_port   = in_data_ff[1:0];
   assign f_pin    = in_data_ff[5:2];
   assign f_value  = in_data_ff[6];
   assign f_lsense = in_data_ff[7];
   assign f_both   = in_data_ff[8];
   assign f_rise   = in_data_ff[9];
   assign f_levels = in_data_ff[21:10];

   always_comb begin
      logic [31:0] lv_wide;
      lv_wide = 32'(f_levels);
      levels  = lv_wide[PINS-1:0];
      for (int i = 0; i < PINS; i++) begin
         bit_sel[i] = (32'(f_pin) == 32'(i));
      end
      port_ok = (32'(f_port) < PORTS);
   end

   // read-modify-write of the addressed port
   always_comb begin
      logic [PINS-1:0] old;
      logic [PINS-1:0] up;
      logic [PINS-1:0] down;
      logic [PINS-1:0] single;
      logic [PINS-1:0] hit;
      logic [PINS-1:0] any;
      logic [31:0]     dd_wide;
      logic [31:0]     de_wide;
      old       = '0;
      up        = '0;
      down      = '0;
      single    = '0;
      hit       = '0;
      any       = '0;
      dd_wide   = '0;
      de_wide   = '0;
      dir_in    = dir_ff;
      latch_in  = latch_ff;
      sample_in = sample_ff;
      level_in  = level_ff;
      dual_in   = dual_ff;
      pol_in    = pol_ff;
      mask_in   = mask_ff;
      edge_in   = edge_ff;
      rd_in     = 1'b0;
      for (int p = 0; p < PORTS; p++) begin
         if (32'(f_port) == 32'(p)) begin
            unique case (in_cmd_ff)
               CMD_SAMPLE: begin
                  old          = sample_ff[p];
                  up           = levels & ~old;
                  down         = old & ~levels;
                  single       = (up & pol_ff[p]) | (down & ~pol_ff[p]);
                  hit          = (dual_ff[p] & (up | down)) | (~dual_ff[p] & single);
                  edge_in[p]   = edge_ff[p] | (hit & ~level_ff[p]);
                  sample_in[p] = levels;
               end
               CMD_DIR:    dir_in[p]   = put_bit(dir_ff[p], bit_sel, f_value);
               CMD_DATA:   latch_in[p] = put_bit(latch_ff[p], bit_sel, f_value);
               CMD_TOGGLE: latch_in[p] = latch_ff[p] ^ bit_sel;
               CMD_READ: begin
                  rd_in = |(bit_sel & ((dir_ff[p] & latch_ff[p]) |
                                       (~dir_ff[p] & sample_ff[p])));
               end
               CMD_IRQ_MODE: begin
                  level_in[p] = put_bit(level_ff[p], bit_sel, f_lsense);
                  if (!f_lsense) begin
                     dual_in[p] = put_bit(dual_ff[p], bit_sel, f_both);
                  end
                  pol_in[p] = put_bit(pol_ff[p], bit_sel, f_rise);
               end
               CMD_ENABLE:  mask_in[p] = mask_ff[p] | bit_sel;
               CMD_DISABLE: mask_in[p] = mask_ff[p] & ~bit_sel;
               CMD_IRQ_STATUS: begin
                  rd_in = |(bit_sel & pending(sample_ff[p], pol_ff[p], level_ff[p],
                                              edge_ff[p], mask_ff[p]));
               end
               CMD_CLEAR_EDGE: edge_in[p] = edge_ff[p] & ~(bit_sel & ~level_ff[p]);
               default: ;
            endcase
            dd_wide = 32'(latch_in[p]);
            de_wide = 32'(dir_in[p]);
         end
         any = any | pending(sample_in[p], pol_in[p], level_in[p], edge_in[p],
                             mask_in[p]);
      end
      dd_in  = dd_wide[DRIVE_W-1:0];
      de_in  = de_wide[DRIVE_W-1:0];
      irq_in = |any;
   end

   // irq of the stored state, checked against the response
   always_comb begin
      logic [PINS-1:0] acc;
      acc = '0;
      for (int p = 0; p < PORTS; p++) begin
         acc = acc | pending(sample_ff[p], pol_ff[p], level_ff[p], edge_ff[p],
                             mask_ff[p]);
      end
      irq_now = |acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dir_ff       <= '0;
         latch_ff     <= '0;
         sample_ff    <= '0;
         level_ff     <= '0;
         dual_ff      <= '0;
         pol_ff       <= '0;
         mask_ff      <= '0;
         edge_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            dir_ff    <= dir_in;
            latch_ff  <= latch_in;
            sample_ff <= sample_in;
            level_ff  <= level_in;
            dual_ff   <= dual_in;
            pol_ff    <= pol_in;
            mask_ff   <= mask_in;
            edge_ff   <= edge_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= cmd_type'(req_tuser);
         in_data_ff <= req_tdata;
      end
      if (move) begin
         rd_ff  <= rd_in;
         dd_ff  <= port_ok ? dd_in : '0;
         de_ff  <= port_ok ? de_in : '0;
         irq_ff <= irq_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, irq_ff, de_ff, dd_ff, rd_ff};

   // checks
   a_irq_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (irq_ff == irq_now))
      else $error("irq does not match stored port state");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !move |=> ($stable(dir_ff) && $stable(latch_ff) && $stable(edge_ff) &&
                 $stable(mask_ff) && $stable(sample_ff)))
      else $error("port registers changed without a word moving");

   a_bad_port_zero: assert property (@(posedge clock) disable iff (reset)
      (move && !port_ok) |=> (dd_ff == '0 && de_ff == '0))
      else $error("out of range port drove data");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !move) |-> !req_tready)
      else $error("input taken while input register is held");

endmodule : gpio_port_with_pin_interrupts
`default_nettype wire
